### hw/rtl/vam_pkg.sv
// Shared constants, CORDIC table, stage type and micro-rotation for vector_angle_magnitude.
package vam_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int STEP_IDX_BITS = 5;
  localparam int ACC_BITS = 32;
  localparam int SCALE_BITS = 60;
  localparam int CW_BITS = 63;

  localparam logic [ACC_BITS-1:0] ACC_HALF_TURN = 32'h8000_0000;

  localparam logic [ACC_BITS-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  localparam int REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_AXIS_LEFT = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FULL_TURN = 1'd1;

  typedef struct packed {
    logic signed [CW_BITS-1:0] x;
    logic signed [CW_BITS-1:0] y;
    logic [ACC_BITS-1:0]       z;
    logic                      zero;
    logic                      num_neg;
  } cord_t;

  function automatic cord_t cord_step(cord_t c, int unsigned i);
    cord_t o;
    logic signed [CW_BITS-1:0] dx;
    logic signed [CW_BITS-1:0] dy;
    o  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + ATAN_TURN[i[STEP_IDX_BITS-1:0]];
    end else begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - ATAN_TURN[i[STEP_IDX_BITS-1:0]];
    end
    return o;
  endfunction

endpackage

### hw/rtl/vam_if.sv
// Valid/ready stream interfaces for the operand and result channels.
interface vam_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vec_x;
  logic signed [COORD_BITS-1:0] vec_y;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;

  modport source (output valid, output vec_x, output vec_y, output ref_x, output ref_y,
                  input ready);
  modport sink   (input valid, input vec_x, input vec_y, input ref_x, input ref_y,
                  output ready);
endinterface

interface vam_out_if #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [ANGLE_BITS:0]  angle_out;
  logic [COORD_BITS-1:0]       magnitude;

  modport source (output valid, output angle_out, output magnitude, input ready);
  modport sink   (input valid, input angle_out, input magnitude, output ready);
endinterface

### hw/rtl/vector_angle_magnitude.sv
// Pipelined CORDIC angle difference and rounded vector magnitude, top level.
//
//   channel    | role   | payload
//   -----------+--------+-------------------------------------------
//   operands   | sink   | vec_x, vec_y, ref_x, ref_y
//   result     | source | angle_out, magnitude
//   wr_*       | write  | wr_index selects register, wr_data bit 0
//
// One transaction per cycle while the output buffer has a free entry; the
// pipeline length is set by the 31 CORDIC micro-rotation stages, or by
// the one-bit-per-stage square root when COORD_BITS exceeds 30.
// Reset clears the stage valid bits, the output buffer and both registers.
// A two-entry output buffer takes results; the pipeline holds only when both
// entries are occupied, so operands are taken while one result waits.
module vector_angle_magnitude #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  vam_in_if.sink                           operands,
  vam_out_if.source                        result,
  input  logic                             wr_en,
  input  logic [vam_pkg::REG_IDX_BITS-1:0] wr_index,
  input  logic                             wr_data
);

  localparam int CW = vam_pkg::CW_BITS;
  localparam int CS = vam_pkg::CORDIC_STEPS;
  localparam int GS = vam_pkg::SCALE_BITS - COORD_BITS;
  localparam int M  = (COORD_BITS + 1 > CS) ? COORD_BITS + 1 : CS;
  localparam int SH = vam_pkg::ACC_BITS - ANGLE_BITS;

  localparam logic signed [32:0] RND = 33'((64'd1 << SH) >> 1);
  localparam logic signed [ANGLE_BITS:0] HALF = (ANGLE_BITS + 1)'(64'd1 << (ANGLE_BITS - 1));
  localparam logic signed [ANGLE_BITS:0] NHALF = -HALF;
  localparam logic signed [ANGLE_BITS+1:0] LIM = (ANGLE_BITS + 2)'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [ANGLE_BITS+1:0] NLIM = -LIM;

  typedef struct packed {
    logic [2*COORD_BITS-1:0] srest;
    logic [COORD_BITS:0]     r;
    logic [COORD_BITS-1:0]   q;
  } root_t;

  function automatic vam_pkg::cord_t pre_rotate(logic signed [COORD_BITS-1:0] num,
                                                logic signed [COORD_BITS-1:0] den);
    vam_pkg::cord_t o;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = CW'(den) <<< GS;
    ys = CW'(num) <<< GS;
    o.zero    = (num == '0) && (den == '0);
    o.num_neg = num[COORD_BITS-1];
    if (den[COORD_BITS-1]) begin
      o.x = -xs;
      o.y = -ys;
      o.z = vam_pkg::ACC_HALF_TURN;
    end else begin
      o.x = xs;
      o.y = ys;
      o.z = '0;
    end
    return o;
  endfunction

  function automatic root_t root_step(root_t c);
    root_t o;
    logic [COORD_BITS+2:0] rr;
    logic [COORD_BITS+2:0] t;
    rr = {c.r, c.srest[2*COORD_BITS-1 -: 2]};
    t  = {1'b0, c.q, 2'b01};
    o.srest = {c.srest[2*COORD_BITS-3:0], 2'b00};
    if (rr >= t) begin
      o.r = (COORD_BITS + 1)'(rr - t);
      o.q = {c.q[COORD_BITS-2:0], 1'b1};
    end else begin
      o.r = (COORD_BITS + 1)'(rr);
      o.q = {c.q[COORD_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [ANGLE_BITS:0] round_angle(vam_pkg::cord_t c);
    logic signed [32:0] zs;
    logic signed [32:0] zr;
    logic signed [ANGLE_BITS:0] r;
    zs = {c.z[31], c.z};
    zr = (zs + RND) >>> SH;
    r  = zr[ANGLE_BITS:0];
    if (c.zero) begin
      r = '0;
    end else if (r == HALF || r == NHALF) begin
      r = c.num_neg ? NHALF : HALF;
    end
    return r;
  endfunction

  logic axis_left;
  logic full_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_left <= 1'b0;
      full_turn <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        vam_pkg::REG_AXIS_LEFT: axis_left <= wr_data;
        vam_pkg::REG_FULL_TURN: full_turn <= wr_data;
      endcase
    end
  end

  logic [1:0] count;
  logic       advance;
  logic       push;
  logic       pop;

  assign advance        = (count != 2'd2);
  assign operands.ready = advance;

  logic [M:0] stage_valid;
  logic       round_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      round_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= {stage_valid[M-1:0], operands.valid};
      round_valid <= stage_valid[M];
    end
  end

  vam_pkg::cord_t vc [0:M];
  vam_pkg::cord_t rc [0:M];
  root_t          rt [1:M];

  logic signed [COORD_BITS-1:0] num_v;
  logic signed [COORD_BITS-1:0] den_v;
  logic signed [COORD_BITS-1:0] num_r;
  logic signed [COORD_BITS-1:0] den_r;
  logic signed [2*COORD_BITS-1:0] px;
  logic signed [2*COORD_BITS-1:0] py;
  logic [2*COORD_BITS-1:0] sqx0;
  logic [2*COORD_BITS-1:0] sqy0;

  assign num_v = axis_left ? operands.vec_x : operands.vec_y;
  assign den_v = axis_left ? operands.vec_y : operands.vec_x;
  assign num_r = axis_left ? operands.ref_x : operands.ref_y;
  assign den_r = axis_left ? operands.ref_y : operands.ref_x;
  assign px    = (2*COORD_BITS)'(operands.vec_x) * (2*COORD_BITS)'(operands.vec_x);
  assign py    = (2*COORD_BITS)'(operands.vec_y) * (2*COORD_BITS)'(operands.vec_y);

  always_ff @(posedge clk) begin
    if (advance) begin
      vc[0] <= pre_rotate(num_v, den_v);
      rc[0] <= pre_rotate(num_r, den_r);
      sqx0  <= px;
      sqy0  <= py;
    end
  end

  for (genvar s = 1; s <= M; s++) begin : g_stage
    vam_pkg::cord_t vc_n;
    vam_pkg::cord_t rc_n;
    root_t          rt_n;

    if (s <= CS) begin : g_cord
      always_comb begin
        vc_n = vam_pkg::cord_step(vc[s-1], s - 1);
        rc_n = vam_pkg::cord_step(rc[s-1], s - 1);
      end
    end else begin : g_cord_hold
      always_comb begin
        vc_n = vc[s-1];
        rc_n = rc[s-1];
      end
    end

    if (s == 1) begin : g_root_load
      always_comb begin
        rt_n.srest = sqx0 + sqy0;
        rt_n.r     = '0;
        rt_n.q     = '0;
      end
    end else if (s - 2 < COORD_BITS) begin : g_root
      always_comb rt_n = root_step(rt[s-1]);
    end else begin : g_root_hold
      always_comb rt_n = rt[s-1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        vc[s] <= vc_n;
        rc[s] <= rc_n;
        rt[s] <= rt_n;
      end
    end
  end

  logic signed [ANGLE_BITS:0] ang_v;
  logic signed [ANGLE_BITS:0] ang_r;
  logic [COORD_BITS-1:0]      mag_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      ang_v <= round_angle(vc[M]);
      ang_r <= round_angle(rc[M]);
      mag_r <= (rt[M].r > {1'b0, rt[M].q}) ? rt[M].q + 1'b1 : rt[M].q;
    end
  end

  logic signed [ANGLE_BITS+1:0] diff;
  logic signed [ANGLE_BITS:0]   angle_new;

  always_comb begin
    diff = (ANGLE_BITS + 2)'(ang_v) - (ANGLE_BITS + 2)'(ang_r);
    priority if (full_turn) begin
      angle_new = {1'b0, diff[ANGLE_BITS-1:0]};
    end else if (diff > LIM) begin
      angle_new = LIM[ANGLE_BITS:0];
    end else if (diff < NLIM) begin
      angle_new = NLIM[ANGLE_BITS:0];
    end else begin
      angle_new = diff[ANGLE_BITS:0];
    end
  end

  logic signed [ANGLE_BITS:0] head_angle;
  logic [COORD_BITS-1:0]      head_mag;
  logic signed [ANGLE_BITS:0] tail_angle;
  logic [COORD_BITS-1:0]      tail_mag;

  assign push = advance && round_valid;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      head_angle <= tail_angle;
      head_mag   <= tail_mag;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head_angle <= angle_new;
      head_mag   <= mag_r;
    end
    if (push && count == 2'd1 && !pop) begin
      tail_angle <= angle_new;
      tail_mag   <= mag_r;
    end
  end

  assign result.valid     = (count != 2'd0);
  assign result.angle_out = head_angle;
  assign result.magnitude = head_mag;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> stage_valid[0])
    else $error("accepted transaction missing from first stage");

  a_drain_second: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && count == 2'd2 |=> result.valid && count == 2'd1)
    else $error("buffered result lost on drain");

  a_hold_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_valid) && $stable(round_valid) && $stable(ang_v))
    else $error("pipeline moved while held");
`endif

endmodule

### sim/tb_vector_angle_magnitude.sv
// Self-checking testbench for vector_angle_magnitude: directed table, then random operands.
`timescale 1ns / 1ps

module tb_vector_angle_magnitude;

  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int GUARD      = 60 - COORD_BITS;
  localparam int ROTATIONS  = 31;
  localparam int PHASE_LEN  = 125;
  localparam int STALL_MAX  = 3000;
  localparam int NPROBE     = 23;

  localparam longint HALF_TURN = longint'(1) <<< (ANGLE_BITS - 1);
  localparam longint ANGLE_LIM = (longint'(1) <<< ANGLE_BITS) - 1;

  localparam logic [31:0] ARC [ROTATIONS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  typedef struct {
    logic signed [ANGLE_BITS:0] angle;
    logic [COORD_BITS-1:0]      length;
  } angle_len_t;

  typedef struct {
    bit left;
    bit full;
    int vx;
    int vy;
    int rx;
    int ry;
    bit typed;
    int angle;
    int length;
  } probe_t;

  probe_t probes [NPROBE] = '{
    '{0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 3, 4, 3, 4, 1, 0, 5},
    '{0, 0, -32768, -32768, -32768, -32768, 1, 0, 46341},
    '{0, 0, -32768, 0, -32768, 0, 1, 0, 32768},
    '{0, 0, 0, -32768, 0, -32768, 1, 0, 32768},
    '{0, 0, -1, 0, -32768, -1, 1, 65535, 1},
    '{0, 0, -32768, -1, -1, 0, 1, -65535, 32768},
    '{0, 0, 0, 1, 1, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 1, 0, 0, 0},
    '{0, 0, -1, 0, 1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 5, 5, 0, 0, 0},
    '{0, 0, 32767, -32768, 1, 0, 0, 0, 0},
    '{0, 0, 32767, 32767, -32768, 32767, 0, 0, 0},
    '{0, 1, -1, 0, -32768, -1, 1, 0, 1},
    '{0, 1, -32768, -1, -1, 0, 1, 0, 32768},
    '{0, 1, 0, -5, 1, 0, 0, 0, 0},
    '{0, 1, 7, -3, -2, 9, 0, 0, 0},
    '{1, 0, 0, -1, -1, -32768, 1, 65535, 1},
    '{1, 0, 1, 0, 0, 1, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 1, 0, 0},
    '{1, 0, -1, -32768, 0, -1, 1, -65535, 32768},
    '{1, 1, 5, -7, -3, 2, 0, 0, 0},
    '{1, 1, 32767, -32768, -32768, 32767, 0, 0, 0}
  };

  logic clk;
  logic rst;
  logic wr_en;
  logic [vam_pkg::REG_IDX_BITS-1:0] wr_index;
  logic wr_data;

  vam_in_if  #(.COORD_BITS(COORD_BITS)) opnd_ch ();
  vam_out_if #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) res_ch ();

  vector_angle_magnitude #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (opnd_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  angle_len_t angle_len_queue [$];
  bit mode_left;
  bit mode_full;
  bit relax;
  int errors = 0;
  int stall_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint turn_angle(longint num, longint den);
    longint x, y, dx, dy, zs, r;
    logic [31:0] z;
    if (num == 0 && den == 0) return 0;
    x = den * (longint'(1) <<< GUARD);
    y = num * (longint'(1) <<< GUARD);
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARC[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARC[i];
      end
    end
    zs = longint'($signed(z));
    r = (zs + (longint'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
    if (r == HALF_TURN || r == -HALF_TURN) r = (num >= 0) ? HALF_TURN : -HALF_TURN;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] rounded_length(longint vx, longint vy);
    longint s, root, trial;
    s = vx * vx + vy * vy;
    root = 0;
    for (int k = COORD_BITS; k >= 0; k--) begin
      trial = root | (longint'(1) <<< k);
      if (trial * trial <= s) root = trial;
    end
    if (s > root * root + root) root = root + 1;
    return COORD_BITS'(root);
  endfunction

  function automatic angle_len_t angle_and_length(int vx, int vy, int rx, int ry);
    angle_len_t o;
    longint a, b, d;
    if (mode_left) begin
      a = turn_angle(vx, vy);
      b = turn_angle(rx, ry);
    end else begin
      a = turn_angle(vy, vx);
      b = turn_angle(ry, rx);
    end
    d = a - b;
    if (mode_full) begin
      d = d & ANGLE_LIM;
    end else begin
      if (d > ANGLE_LIM) d = ANGLE_LIM;
      if (d < -ANGLE_LIM) d = -ANGLE_LIM;
    end
    o.angle  = (ANGLE_BITS+1)'(d);
    o.length = rounded_length(vx, vy);
    return o;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int tiny_coord();
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  task automatic pick_operands(output int vx, output int vy, output int rx, output int ry);
    vx = any_coord();
    vy = any_coord();
    rx = any_coord();
    ry = any_coord();
    case ($urandom_range(0, 7))
      1: begin
        vx = tiny_coord();
        vy = tiny_coord();
        rx = tiny_coord();
        ry = tiny_coord();
      end
      2: begin
        vx = edge_coord();
        vy = edge_coord();
        rx = edge_coord();
        ry = edge_coord();
      end
      3: begin
        if ($urandom_range(0, 1)) vx = 0;
        else vy = 0;
        if ($urandom_range(0, 1)) rx = 0;
        else ry = 0;
      end
      4: begin
        rx = mode_left ? 0 : 1;
        ry = mode_left ? 1 : 0;
      end
      5: begin
        rx = $urandom_range(0, 1) ? vx : -vx;
        ry = (rx == vx) ? vy : -vy;
        if (rx > 32767) rx = vx;
        if (ry > 32767) ry = vy;
      end
      default: ;
    endcase
  endtask

  task automatic send_operands(int vx, int vy, int rx, int ry, bit typed, int angle,
                               int length);
    angle_len_t e;
    while (!relax && $urandom_range(0, 99) < 35) begin
      opnd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    opnd_ch.valid <= 1'b1;
    opnd_ch.vec_x <= COORD_BITS'(vx);
    opnd_ch.vec_y <= COORD_BITS'(vy);
    opnd_ch.ref_x <= COORD_BITS'(rx);
    opnd_ch.ref_y <= COORD_BITS'(ry);
    @(posedge clk);
    while (!opnd_ch.ready) @(posedge clk);
    if (typed) begin
      e.angle  = (ANGLE_BITS+1)'(angle);
      e.length = COORD_BITS'(length);
    end else begin
      e = angle_and_length(vx, vy, rx, ry);
    end
    angle_len_queue.push_back(e);
  endtask

  task automatic drain_results();
    opnd_ch.valid <= 1'b0;
    while (angle_len_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(bit left, bit full);
    wr_en    <= 1'b1;
    wr_index <= vam_pkg::REG_AXIS_LEFT;
    wr_data  <= left;
    @(posedge clk);
    wr_index <= vam_pkg::REG_FULL_TURN;
    wr_data  <= full;
    @(posedge clk);
    wr_en     <= 1'b0;
    mode_left = left;
    mode_full = full;
  endtask

  always @(posedge clk) begin
    res_ch.ready <= relax || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    angle_len_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (angle_len_queue.size() == 0) begin
        $error("unexpected result: angle_out %0d magnitude %0d",
               res_ch.angle_out, res_ch.magnitude);
        errors++;
      end else begin
        e = angle_len_queue.pop_front();
        if (res_ch.angle_out !== e.angle) begin
          $error("angle_out: expected %0d, actual %0d", e.angle, res_ch.angle_out);
          errors++;
        end
        if (res_ch.magnitude !== e.length) begin
          $error("magnitude: expected %0d, actual %0d", e.length, res_ch.magnitude);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((opnd_ch.valid && opnd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int vx, vy, rx, ry;
    bit left, full;
    relax         = 1'b0;
    mode_left     = 1'b0;
    mode_full     = 1'b0;
    rst           <= 1'b1;
    wr_en         <= 1'b0;
    wr_index      <= vam_pkg::REG_AXIS_LEFT;
    wr_data       <= 1'b0;
    opnd_ch.valid <= 1'b0;
    opnd_ch.vec_x <= '0;
    opnd_ch.vec_y <= '0;
    opnd_ch.ref_x <= '0;
    opnd_ch.ref_y <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < NPROBE; n++) begin
      if (probes[n].left != mode_left || probes[n].full != mode_full) begin
        drain_results();
        set_mode(probes[n].left, probes[n].full);
      end
      send_operands(probes[n].vx, probes[n].vy, probes[n].rx, probes[n].ry,
                    probes[n].typed, probes[n].angle, probes[n].length);
    end

    for (int phase = 0; phase < 4; phase++) begin
      left = (phase == 1 || phase == 2);
      full = (phase == 0 || phase == 2);
      drain_results();
      set_mode(left, full);
      for (int n = 0; n < PHASE_LEN; n++) begin
        relax = (phase == 1 && n >= 20 && n < 80);
        if (phase == 2 && n == 60) drain_results();
        pick_operands(vx, vy, rx, ry);
        send_operands(vx, vy, rx, ry, 1'b0, 0, 0);
      end
    end
    relax = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/vam_pkg.sv
hw/rtl/vam_if.sv
hw/rtl/vector_angle_magnitude.sv
sim/tb_vector_angle_magnitude.sv
